// ===== hdl/sra_pkg.sv =====
// Shared types and constants for the sliding-window RMS gain control block.
package sra_pkg;

    localparam int WIN_DEPTH = 8192;
    localparam int AW        = 13;
    localparam int SUM_W     = 44;
    localparam int GAIN_W    = 24;
    localparam int GFRAC     = 16;
    localparam int DIV_W     = 60;
    localparam int DVS_W     = 34;
    localparam int ROOT_W    = 30;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(WIN_DEPTH - 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 24'd65536;
    localparam logic [GAIN_W-1:0] LOW_GAIN   = 24'd655;
    localparam logic [DIV_W-1:0]  FLOOR_GAIN = 60'd65536000000;
    localparam logic [31:0]       RECIP10    = 32'hCCCC_CCCD;

    localparam logic [CFG_IDX_W-1:0] CFG_WLEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOUD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FSCL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP  = 3'd4;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SQ, S_SUM, S_OUT, S_DIV1, S_SQL, S_SQRT,
        S_MUL, S_NUM, S_DIV2, S_GAIN
    } t_state;

    typedef struct packed {
        logic          clr;
        logic [AW-1:0] clr_addr;
        logic          load_in;
        logic          sq;
        logic          sum;
        logic          out_load;
        logic          div_ld_ms;
        logic          div_ld_g;
        logic          div_step;
        logic          sq_ld;
        logic          sq_step;
        logic          mul;
        logic          gain_upd;
    } t_cmd;

    typedef struct packed {
        logic sum_zero;
        logic root_zero;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/sra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/sra_ctrl.sv =====
// Sequencer for the gain control block: clear pass, sample path, gain update.
module sra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sra_pkg::t_stat i_stat,
    output sra_pkg::t_cmd  o_cmd
);
    import sra_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]     r_clr, n_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        n_clr   = r_clr;
        unique case (r_state)
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid) n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) n_state = i_stat.sum_zero ? S_GAIN : S_DIV1;
            end
            S_DIV1: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) n_state = S_SQL;
            end
            S_SQL:  n_state = S_SQRT;
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) n_state = S_MUL;
            end
            S_MUL:  n_state = i_stat.root_zero ? S_GAIN : S_NUM;
            S_NUM:  n_state = S_DIV2;
            S_DIV2: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) n_state = S_GAIN;
            end
            S_GAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_addr = r_clr;
        o_stall        = (r_state != S_IDLE);
        unique case (r_state)
            S_CLR:  o_cmd.clr = 1'b1;
            S_IDLE: o_cmd.load_in = i_valid;
            S_SQ:   o_cmd.sq = 1'b1;
            S_SUM:  o_cmd.sum = 1'b1;
            S_OUT: begin
                o_cmd.out_load  = i_stat.out_free;
                o_cmd.div_ld_ms = i_stat.out_free;
            end
            S_DIV1: o_cmd.div_step = 1'b1;
            S_SQL:  o_cmd.sq_ld = 1'b1;
            S_SQRT: o_cmd.sq_step = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_NUM:  o_cmd.div_ld_g = 1'b1;
            S_DIV2: o_cmd.div_step = 1'b1;
            S_GAIN: o_cmd.gain_upd = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

// ===== hdl/sra_dp.sv =====
// Datapath: config registers, sample ring, sum of squares, divider, root, gain.
module sra_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sra_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic signed [15:0]             i_sample_in,
    output logic signed [15:0]             o_sample_out,
    output logic                           o_valid,
    input  logic                           i_stall,
    input  sra_pkg::t_cmd                  i_cmd,
    output sra_pkg::t_stat                 o_stat
);
    import sra_pkg::*;

    // configuration
    logic [13:0]       r_wlen;
    logic [23:0]       r_loud;
    logic [23:0]       r_ceil;
    logic [14:0]       r_fs;
    logic              r_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= 14'd96;
            r_loud <= 24'd13107;
            r_ceil <= 24'd196608;
            r_fs   <= 15'd30000;
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WLEN: r_wlen <= i_cfg_data[13:0];
                CFG_LOUD: r_loud <= i_cfg_data;
                CFG_CEIL: r_ceil <= i_cfg_data;
                CFG_FSCL: r_fs   <= i_cfg_data[14:0];
                CFG_SWAP: r_swap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [13:0] len;
    always_comb begin
        len = r_wlen;
        if (r_wlen == '0) len = 14'd1;
        else if (r_wlen > 14'(WIN_DEPTH)) len = 14'(WIN_DEPTH);
    end

    // sample ring
    logic [AW-1:0]      r_pos;
    logic [15:0]        r_x;
    logic [16:0]        r_mag;
    logic [15:0]        ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [15:0]        ram_wdata;

    assign ram_we    = i_cmd.clr | i_cmd.sq;
    assign ram_waddr = i_cmd.clr ? i_cmd.clr_addr : r_pos;
    assign ram_wdata = i_cmd.clr ? 16'd0 : r_x;

    sra_ram #(.WIDTH(16), .DEPTH(WIN_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    logic [15:0] sw;
    logic [16:0] sw_mag, old_mag;
    assign sw      = r_swap ? {i_sample_in[7:0], i_sample_in[15:8]} : i_sample_in;
    assign sw_mag  = sw[15] ? (17'd0 - {1'b1, sw}) : {1'b0, sw};
    assign old_mag = ram_rdata[15] ? (17'd0 - {1'b1, ram_rdata}) : {1'b0, ram_rdata};

    // products, sum, output value
    logic [33:0]     r_oldsq, r_xsq;
    logic [40:0]     r_prod;
    logic [15:0]     r_lim;
    logic [SUM_W-1:0] r_sum;
    logic [15:0]     r_res;
    logic [18:0]     fs9;
    logic [50:0]     lim_full;
    logic [24:0]     p_sh;
    logic [15:0]     p_clip;
    logic [13:0]     pos_inc;
    logic [GAIN_W-1:0] r_gain;

    assign fs9      = {1'b0, r_fs, 3'b000} + {4'b0, r_fs};
    assign lim_full = 51'(fs9) * 51'(RECIP10);
    assign p_sh     = r_prod[40:16];
    assign p_clip   = (p_sh > {9'b0, r_lim}) ? r_lim : p_sh[15:0];
    assign pos_inc  = {1'b0, r_pos} + 14'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_cmd.sum) begin
            r_sum <= r_sum - {10'b0, r_oldsq} + {10'b0, r_xsq};
            r_pos <= (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= sw;
            r_mag <= sw_mag;
        end
        if (i_cmd.sq) begin
            r_oldsq <= old_mag * old_mag;
            r_xsq   <= r_mag * r_mag;
            r_prod  <= r_gain * r_mag;
            r_lim   <= lim_full[50:35];
        end
        if (i_cmd.sum) begin
            r_res <= r_x[15] ? (16'd0 - p_clip) : p_clip;
        end
    end

    // output register
    logic        r_ovalid;
    logic [15:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out <= r_res;
    end

    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;

    // restoring divider, one quotient bit per cycle
    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem, r_dvs;
    logic [DVS_W:0]   rem_sh, rem_sub;
    logic             div_ge;

    // digit-by-digit square root, two radicand bits per cycle
    logic [DIV_W-1:0]  r_ms;
    logic [31:0]       r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [33:0]       srem_sh, trial;
    logic              sq_ge;
    logic [38:0]       r_fl;
    logic [41:0]       fl7;

    assign rem_sh  = {r_rem, r_q[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign div_ge  = rem_sh >= {1'b0, r_dvs};

    assign srem_sh = {r_srem, r_ms[DIV_W-1 -: 2]};
    assign trial   = {2'b0, r_root, 2'b01};
    assign sq_ge   = srem_sh >= trial;

    assign fl7 = {r_fl, 3'b000} - {3'b0, r_fl};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_ld_ms) begin
            r_q   <= {r_sum, 16'b0};
            r_rem <= '0;
            r_dvs <= {20'b0, len};
        end else if (i_cmd.div_ld_g) begin
            r_q   <= {10'b0, fl7, 8'b0};
            r_rem <= '0;
            r_dvs <= {1'b0, r_root, 3'b000} + {3'b0, r_root, 1'b0};
        end else if (i_cmd.div_step) begin
            r_q   <= {r_q[DIV_W-2:0], div_ge};
            r_rem <= div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
        if (i_cmd.sq_ld) begin
            r_ms   <= r_q;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_ms   <= {r_ms[DIV_W-3:0], 2'b00};
            r_srem <= sq_ge ? 32'(srem_sh - trial) : srem_sh[31:0];
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
        end
        if (i_cmd.mul) begin
            r_fl <= r_fs * r_loud;
        end
    end

    // gain selection and limiting
    logic [DIV_W-1:0] cand;
    logic [GAIN_W-1:0] gain_nx;

    always_comb begin
        if (r_sum == '0)                cand = {36'b0, GAIN_ONE};
        else if (r_root == '0)          cand = '0;
        else if (r_q > FLOOR_GAIN)      cand = '0;
        else                            cand = r_q;
        if (cand > {36'b0, r_ceil})     gain_nx = r_ceil;
        else if (cand < {36'b0, LOW_GAIN}) gain_nx = LOW_GAIN;
        else                            gain_nx = cand[GAIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
        end else if (i_cmd.gain_upd) begin
            r_gain <= gain_nx;
        end
    end

    assign o_stat.sum_zero  = (r_sum == '0);
    assign o_stat.root_zero = (r_root == '0);
    assign o_stat.out_free  = !r_ovalid || !i_stall;
endmodule

// ===== hdl/sliding_rms_agc.sv =====
// Sliding-window RMS automatic gain control, top level.
// o_valid rises after states S_SQ, S_SUM and S_OUT, once S_OUT finds the output register free.
// Samples are taken one at a time (o_stall high until the gain update), each through two 60-step
// bit-serial divisions (mean square, gain) and a 30-step square root; a zero window sum skips all
// three and a zero root the gain division. Reset (synchronous, active low) runs a pass zeroing the
// 8192-entry sample ring; no input is taken during it. Config writes are taken anytime.
module sliding_rms_agc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sra_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [15:0]             i_sample_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [15:0]             o_sample_out
);
    import sra_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sra_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );
endmodule
